[rtl/leib_pkg.sv]
package leib_pkg;

  localparam int unsigned BUFFER_DEPTH = 128;
  localparam int unsigned SLOT_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned IDX_W        = SLOT_W + 1;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_Z = 8'h1a;
  localparam logic [7:0] KEY_DEL    = 8'h7f;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_READ    = 3'd2,
    ST_EOF     = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_code;
    logic       request_started;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic [7:0] read_byte;
    logic       line_end;
  } out_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

[rtl/leib_ring.sv]
module leib_ring (
  input  logic               clk_i,
  input  leib_pkg::mem_req_t req_i,
  output logic [7:0]         rd_data_o
);
  import leib_pkg::*;

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/leib_ctrl.sv]
module leib_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  leib_pkg::in_t      in_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output leib_pkg::out_t     res_o,
  output leib_pkg::mem_req_t mem_req_o,
  input  logic [7:0]         mem_rdata_i
);
  import leib_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KILL = 4'b0010,
    S_POP  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic [IDX_W-1:0] cm_q, cm_d;
  logic [IDX_W-1:0] ed_q, ed_d;
  logic [IDX_W-1:0] erase_q, erase_d;
  logic             started_q, started_d;
  out_t             res_q, res_d;
  mem_req_t         mem_req;

  logic [IDX_W-1:0] ed_m1;
  logic [IDX_W-1:0] ed_m2;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] fill_inc;
  logic [IDX_W-1:0] cm_fill;
  logic [7:0]       key_char;

  assign ed_m1    = ed_q - 1'b1;
  assign ed_m2    = ed_q - IDX_W'(2);
  assign fill     = ed_q - rd_q;
  assign fill_inc = fill + 1'b1;
  assign cm_fill  = cm_q - rd_q;
  assign key_char = (in_i.key_code == KEY_CR) ? KEY_LF : in_i.key_code;

  always_comb begin
    state_d   = state_q;
    rd_d      = rd_q;
    cm_d      = cm_q;
    ed_d      = ed_q;
    erase_d   = erase_q;
    started_d = started_q;
    res_d     = res_q;
    mem_req   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d        = '0;
          res_d.status = ST_IGNORED;
          started_d    = in_i.request_started;
          erase_d      = '0;
          state_d      = S_HOLD;
          if (in_i.opcode == OP_KEY) begin
            if (in_i.key_code inside {KEY_CTRL_Z, KEY_CTRL_P, KEY_NUL}) begin
              // consumed without effect
            end else if (in_i.key_code == KEY_CTRL_U) begin
              if (ed_q != cm_q) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ed_m1[SLOT_W-1:0];
                state_d         = S_KILL;
              end
            end else if (in_i.key_code inside {KEY_BS, KEY_DEL}) begin
              if (ed_q != cm_q) begin
                ed_d              = ed_m1;
                res_d.erase_count = 8'd1;
                res_d.status      = ST_OK;
              end
            end else if (!fill[IDX_W-1]) begin
              mem_req.wr_en    = 1'b1;
              mem_req.wr_addr  = ed_q[SLOT_W-1:0];
              mem_req.wr_data  = key_char;
              ed_d             = ed_q + 1'b1;
              res_d.echo_valid = 1'b1;
              res_d.echo_char  = key_char;
              res_d.status     = ST_OK;
              // commit on newline, end of file or a full ring
              if (key_char == KEY_LF || key_char == KEY_CTRL_D ||
                  fill_inc == IDX_W'(BUFFER_DEPTH)) begin
                cm_d = ed_q + 1'b1;
              end
            end
          end else begin
            if (rd_q == cm_q) begin
              res_d.status = ST_EMPTY;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = rd_q[SLOT_W-1:0];
              state_d         = S_POP;
            end
          end
        end
      end

      S_KILL: begin
        // one erased byte per cycle; stop at a newline or the commit point
        if (mem_rdata_i != KEY_LF) begin
          ed_d    = ed_m1;
          erase_d = erase_q + 1'b1;
          if (ed_m1 != cm_q) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ed_m2[SLOT_W-1:0];
          end else begin
            state_d = S_HOLD;
          end
        end else begin
          state_d = S_HOLD;
        end
        res_d.erase_count = 8'(erase_d);
        res_d.status      = (erase_d != '0) ? ST_OK : ST_IGNORED;
      end

      S_POP: begin
        if (mem_rdata_i == KEY_CTRL_D) begin
          // push back when the request already got bytes
          if (!started_q) begin
            rd_d = rd_q + 1'b1;
          end
          res_d.status = ST_EOF;
        end else begin
          rd_d           = rd_q + 1'b1;
          res_d.status   = ST_READ;
          res_d.read_byte = mem_rdata_i;
          res_d.line_end = (mem_rdata_i == KEY_LF);
        end
        state_d = S_HOLD;
      end

      S_HOLD: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      cm_q      <= '0;
      ed_q      <= '0;
      erase_q   <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      cm_q      <= cm_d;
      ed_q      <= ed_d;
      erase_q   <= erase_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_HOLD);
  assign res_o       = res_q;
  assign mem_req_o   = mem_req;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= IDX_W'(BUFFER_DEPTH))
    else $error("ring holds more bytes than its depth");

  a_commit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cm_fill <= fill)
    else $error("commit index passed edit index");

  a_read_only_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_q != $past(rd_q)) |-> ($past(state_q) == S_POP))
    else $error("read index moved outside a pop");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == S_IDLE && in_valid_i && in_i.opcode == OP_KEY))
    else $error("ring written without an accepted key beat");
`endif

endmodule

[rtl/line_editing_input_buffer.sv]
// Flow: a key or empty read is accepted in S_IDLE, its result is registered in S_HOLD
// and then in the output register; a pop reads the ring in S_POP before S_HOLD, and a
// Ctrl-U line kill walks S_KILL at one erased byte per cycle before S_HOLD. A new item
// is taken once the last result leaves S_HOLD, also while one waits at the output.
// Reset: read, commit and edit indices clear to zero; the ring contents are not cleared.
module line_editing_input_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  leib_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output leib_pkg::out_t out_o
);
  import leib_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       res_valid;
  logic       res_stall;
  out_t       res;
  logic       out_valid_q;
  out_t       out_q;

  leib_ring u_ring (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

  leib_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // hold the result beat until the sink takes it
  assign res_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
